// ===== sv/ppo_pkg.sv =====
// Shared types, constants and helpers of the polyline offset core.
`timescale 1ns / 1ps

package ppo_pkg;

    localparam int DATA_W         = 24;
    localparam int MAX_POINTS_DEF = 64;

    // Iterative unit geometry.
    localparam int UNIT_W = 64;
    localparam int LOW_W  = 32;
    localparam int STEP_W = 6;

    localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(32);
    localparam logic [STEP_W-1:0] UDIV_STEPS = STEP_W'(32);
    localparam logic [STEP_W-1:0] CDIV_STEPS = STEP_W'(27);

    // Corner displacement limit (magnitude).
    localparam logic [26:0] CORNER_CAP = 27'd67108864;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PASS,
        ST_L2X,
        ST_L2Y,
        ST_SQ_GO,
        ST_SQRT,
        ST_UX_GO,
        ST_UX,
        ST_UY_GO,
        ST_NX,
        ST_UY,
        ST_NY_MUL,
        ST_NY,
        ST_SHIFT,
        ST_DEN1,
        ST_DEN2,
        ST_NUM1,
        ST_NUM2,
        ST_CHK,
        ST_MLO,
        ST_MHI,
        ST_DGO,
        ST_DWAIT,
        ST_DCAP,
        ST_CORNER,
        ST_EMIT_A,
        ST_TAIL,
        ST_END,
        ST_ECHO
    } t_state;

    typedef struct packed {
        logic              start;
        logic              sqrt;
        logic [STEP_W-1:0] steps;
    } t_unit_cmd;

    function automatic logic signed [DATA_W-1:0] sat24(input logic signed [31:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > 32'sd8388607) begin
            res = 24'sh7FFFFF;
        end else if (v < -32'sd8388608) begin
            res = 24'sh800000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/ppo_iter_unit.sv =====
// Shared bit-serial unit: restoring divide or digit-by-digit square root.
`timescale 1ns / 1ps

module ppo_iter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppo_pkg::t_unit_cmd            i_cmd,
    input  logic [ppo_pkg::UNIT_W-1:0]    i_rem,
    input  logic [ppo_pkg::LOW_W-1:0]     i_low,
    input  logic [ppo_pkg::UNIT_W-1:0]    i_den,
    output logic                          o_done,
    output logic [ppo_pkg::LOW_W-1:0]     o_q
);

    logic [ppo_pkg::UNIT_W-1:0] r_a;
    logic [ppo_pkg::UNIT_W-1:0] r_b;
    logic [ppo_pkg::UNIT_W-1:0] r_bit;
    logic [ppo_pkg::LOW_W-1:0]  r_low;
    logic [ppo_pkg::LOW_W-1:0]  r_q;
    logic [ppo_pkg::STEP_W-1:0] r_cnt;
    logic                       r_sqrt;

    logic [ppo_pkg::UNIT_W-1:0] c_t;
    logic [ppo_pkg::UNIT_W-1:0] c_sub;
    logic [ppo_pkg::UNIT_W:0]   c_diff;
    logic                       c_ge;

    assign c_t    = r_sqrt ? r_a : {r_a[ppo_pkg::UNIT_W-2:0], r_low[ppo_pkg::LOW_W-1]};
    // root bits always sit above the trial bit, so OR is the sum
    assign c_sub  = r_sqrt ? (r_b | r_bit) : r_b;
    assign c_diff = {1'b0, c_t} - {1'b0, c_sub};
    assign c_ge   = ~c_diff[ppo_pkg::UNIT_W];

    assign o_done = (r_cnt == ppo_pkg::STEP_W'(1));
    assign o_q    = r_sqrt ? r_b[ppo_pkg::LOW_W-1:0] : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.start) begin
            r_cnt <= i_cmd.steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - ppo_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a    <= i_rem;
            r_b    <= i_cmd.sqrt ? '0 : i_den;
            r_bit  <= ppo_pkg::UNIT_W'(1) << 62;
            r_low  <= i_low;
            r_q    <= '0;
            r_sqrt <= i_cmd.sqrt;
        end else if (r_cnt != '0) begin
            if (r_sqrt) begin
                if (c_ge) begin
                    r_a <= c_diff[ppo_pkg::UNIT_W-1:0];
                    r_b <= (r_b >> 1) | r_bit;
                end else begin
                    r_b <= r_b >> 1;
                end
                r_bit <= r_bit >> 2;
            end else begin
                r_a   <= c_ge ? c_diff[ppo_pkg::UNIT_W-1:0] : c_t;
                r_q   <= {r_q[ppo_pkg::LOW_W-2:0], c_ge};
                r_low <= r_low << 1;
            end
        end
    end

endmodule

// ===== sv/polyline_parallel_offset_core.sv =====
// Top level of the polyline offset core: sequencer, multiplier and polyline state.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// cfg       in         i_cfg_we                  i_cfg_data (offset, signed Q15.8)
// in        in         i_in_valid / o_in_stall   i_in_x, i_in_y, i_in_last
// out       out        o_out_valid / i_out_stall o_out_x, o_out_y, o_out_last
//
// One item at a time. Zero offset or a repeated vertex skips the divide / root unit. A
// vertex opening a segment runs a root and two normal divides; one closing a corner adds
// two corner divides (none on parallel segments, fewer when a corner displacement hits
// the cap), all on the shared one-bit-per-cycle divide / root unit.
// A last vertex adds the closing end; the final item of a lone point is repeated up to
// MAX_POINTS times, one per cycle while the output is not stalled.
// Reset is synchronous, active low, and clears offset and polyline state at once.
// A stalled output holds its item; the sequencer waits while the output register is full and stalled.

module polyline_parallel_offset_core #(
    parameter int MAX_POINTS = ppo_pkg::MAX_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic signed [ppo_pkg::DATA_W-1:0]   i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [ppo_pkg::DATA_W-1:0]   i_in_x,
    input  logic signed [ppo_pkg::DATA_W-1:0]   i_in_y,
    input  logic                                i_in_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ppo_pkg::DATA_W-1:0]   o_out_x,
    output logic signed [ppo_pkg::DATA_W-1:0]   o_out_y,
    output logic                                o_out_last
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    ppo_pkg::t_state r_state, n_state;

    // configuration and polyline state
    logic signed [23:0] r_dist;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_left;
    logic               r_have;
    logic signed [23:0] r_prev_x, r_prev_y;
    logic signed [23:0] r_ssx, r_ssy, r_sex, r_sey;
    logic signed [24:0] r_sdx, r_sdy;

    // current item and work registers
    logic signed [23:0] r_x, r_y;
    logic               r_last;
    logic signed [24:0] r_dx, r_dy;
    logic [49:0]        r_l2;
    logic [30:0]        r_s;
    logic signed [25:0] r_nx, r_ny;
    logic signed [23:0] r_ax, r_ay, r_bx, r_by;
    logic signed [50:0] r_den, r_num;
    logic [51:0]        r_acc;
    logic [26:0]        r_mx, r_my;
    logic               r_pass;
    logic signed [59:0] r_prod;

    // output register
    logic               r_ovalid, n_ovalid;
    logic signed [23:0] r_ox, r_oy;
    logic               r_olast;

    // control from the output decoder
    logic signed [32:0] c_mul_a;
    logic signed [26:0] c_mul_b;
    ppo_pkg::t_unit_cmd c_cmd;
    logic [63:0]        c_urem;
    logic [31:0]        c_ulow;
    logic [63:0]        c_uden;
    logic               c_emit;
    logic signed [23:0] c_ex, c_ey;
    logic               c_elast;

    logic               u_done;
    logic [31:0]        u_q;

    // combinational helpers
    logic               in_acc, slot_free, new_seg;
    logic signed [24:0] c_dx, c_dy;
    logic [24:0]        adx, ady, asdx, asdy, a_sel;
    logic [23:0]        dm;
    logic [60:0]        c_un_x;
    logic [59:0]        c_rnd;
    logic [24:0]        c_m;
    logic signed [25:0] c_nval;
    logic [50:0]        num_mag, den_mag;
    logic [76:0]        c_full;
    logic [77:0]        c_n;
    logic [51:0]        c_dd;
    logic               c_ovf;
    logic [26:0]        c_qcap;
    logic               c_sn;
    logic signed [27:0] c_cx, c_cy;
    logic [CNT_W-1:0]   c_cnt_inc;

    assign in_acc    = i_in_valid && (r_state == ppo_pkg::ST_IDLE);
    assign o_in_stall = (r_state != ppo_pkg::ST_IDLE);
    assign slot_free = !r_ovalid || !i_out_stall;

    assign c_dx = 25'(i_in_x) - 25'(r_prev_x);
    assign c_dy = 25'(i_in_y) - 25'(r_prev_y);
    assign new_seg = (r_count != '0) && ((i_in_x != r_prev_x) || (i_in_y != r_prev_y));

    assign adx  = r_dx[24] ? 25'(-r_dx) : 25'(r_dx);
    assign ady  = r_dy[24] ? 25'(-r_dy) : 25'(r_dy);
    assign asdx = r_sdx[24] ? 25'(-r_sdx) : 25'(r_sdx);
    assign asdy = r_sdy[24] ? 25'(-r_sdy) : 25'(r_sdy);
    assign a_sel = r_pass ? asdy : asdx;
    assign dm   = r_dist[23] ? 24'(-r_dist) : 24'(r_dist);

    // unit-normal numerator of the y normal: |dx| * 2^36 + S / 2
    assign c_un_x = {adx, 36'd0} + 61'(r_s >> 1);

    // round the scaled normal from 30 fraction bits
    assign c_rnd  = 60'(r_prod) + 60'd536870912;
    assign c_m    = c_rnd[54:30];
    assign c_nval = $signed({1'b0, c_m});

    assign num_mag = r_num[50] ? 51'(-r_num) : 51'(r_num);
    assign den_mag = r_den[50] ? 51'(-r_den) : 51'(r_den);

    // corner quotient: (2 * a * |num| + |den|) / (2 * |den|)
    assign c_full = 77'(r_acc) + (77'(r_prod[50:0]) << 26);
    assign c_n    = {c_full, 1'b0} + 78'(den_mag);
    assign c_dd   = {den_mag, 1'b0};
    assign c_ovf  = ({1'b0, c_n[77:27]} >= c_dd);
    assign c_qcap = (u_q[26:0] > ppo_pkg::CORNER_CAP) ? ppo_pkg::CORNER_CAP : u_q[26:0];

    assign c_sn = (r_num[50] != r_den[50]);
    assign c_cx = (r_sdx[24] != c_sn) ? -$signed({1'b0, r_mx}) : $signed({1'b0, r_mx});
    assign c_cy = (r_sdy[24] != c_sn) ? -$signed({1'b0, r_my}) : $signed({1'b0, r_my});

    assign c_cnt_inc = (r_count < CNT_W'(MAX_POINTS)) ? r_count + CNT_W'(1) : r_count;

    ppo_iter_unit u_iter (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (c_cmd),
        .i_rem  (c_urem),
        .i_low  (c_ulow),
        .i_den  (c_uden),
        .o_done (u_done),
        .o_q    (u_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ppo_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (r_dist == '0) begin
                        n_state = ppo_pkg::ST_PASS;
                    end else if (new_seg) begin
                        n_state = ppo_pkg::ST_L2X;
                    end else begin
                        n_state = ppo_pkg::ST_TAIL;
                    end
                end
            end
            ppo_pkg::ST_PASS:   if (slot_free) n_state = ppo_pkg::ST_IDLE;
            ppo_pkg::ST_L2X:    n_state = ppo_pkg::ST_L2Y;
            ppo_pkg::ST_L2Y:    n_state = ppo_pkg::ST_SQ_GO;
            ppo_pkg::ST_SQ_GO:  n_state = ppo_pkg::ST_SQRT;
            ppo_pkg::ST_SQRT:   if (u_done) n_state = ppo_pkg::ST_UX_GO;
            ppo_pkg::ST_UX_GO:  n_state = ppo_pkg::ST_UX;
            ppo_pkg::ST_UX:     if (u_done) n_state = ppo_pkg::ST_UY_GO;
            ppo_pkg::ST_UY_GO:  n_state = ppo_pkg::ST_NX;
            ppo_pkg::ST_NX:     n_state = ppo_pkg::ST_UY;
            ppo_pkg::ST_UY:     if (u_done) n_state = ppo_pkg::ST_NY_MUL;
            ppo_pkg::ST_NY_MUL: n_state = ppo_pkg::ST_NY;
            ppo_pkg::ST_NY:     n_state = ppo_pkg::ST_SHIFT;
            ppo_pkg::ST_SHIFT:  n_state = r_have ? ppo_pkg::ST_DEN1 : ppo_pkg::ST_EMIT_A;
            ppo_pkg::ST_DEN1:   n_state = ppo_pkg::ST_DEN2;
            ppo_pkg::ST_DEN2:   n_state = ppo_pkg::ST_NUM1;
            ppo_pkg::ST_NUM1:   n_state = ppo_pkg::ST_NUM2;
            ppo_pkg::ST_NUM2:   n_state = ppo_pkg::ST_CHK;
            ppo_pkg::ST_CHK:    n_state = (r_den == '0) ? ppo_pkg::ST_EMIT_A : ppo_pkg::ST_MLO;
            ppo_pkg::ST_MLO:    n_state = ppo_pkg::ST_MHI;
            ppo_pkg::ST_MHI:    n_state = ppo_pkg::ST_DGO;
            ppo_pkg::ST_DGO: begin
                if (!c_ovf) begin
                    n_state = ppo_pkg::ST_DWAIT;
                end else begin
                    n_state = r_pass ? ppo_pkg::ST_CORNER : ppo_pkg::ST_MLO;
                end
            end
            ppo_pkg::ST_DWAIT:  if (u_done) n_state = ppo_pkg::ST_DCAP;
            ppo_pkg::ST_DCAP:   n_state = r_pass ? ppo_pkg::ST_CORNER : ppo_pkg::ST_MLO;
            ppo_pkg::ST_CORNER: if (slot_free) n_state = ppo_pkg::ST_TAIL;
            ppo_pkg::ST_EMIT_A: if (slot_free) n_state = ppo_pkg::ST_TAIL;
            ppo_pkg::ST_TAIL: begin
                if (!r_last) begin
                    n_state = ppo_pkg::ST_IDLE;
                end else begin
                    n_state = r_have ? ppo_pkg::ST_END : ppo_pkg::ST_ECHO;
                end
            end
            ppo_pkg::ST_END:    if (slot_free) n_state = ppo_pkg::ST_IDLE;
            ppo_pkg::ST_ECHO: begin
                if (slot_free && (r_left == CNT_W'(1))) n_state = ppo_pkg::ST_IDLE;
            end
            default:            n_state = ppo_pkg::ST_IDLE;
        endcase
    end

    // control decode: multiplier operands, unit commands, emitted item
    always_comb begin
        c_mul_a = '0;
        c_mul_b = '0;
        c_cmd   = '0;
        c_urem  = '0;
        c_ulow  = '0;
        c_uden  = '0;
        c_emit  = 1'b0;
        c_ex    = r_x;
        c_ey    = r_y;
        c_elast = 1'b0;
        case (r_state)
            ppo_pkg::ST_PASS: begin
                c_emit  = slot_free;
                c_elast = r_last;
            end
            ppo_pkg::ST_L2X: begin
                c_mul_a = 33'(r_dx);
                c_mul_b = 27'(r_dx);
            end
            ppo_pkg::ST_L2Y: begin
                c_mul_a = 33'(r_dy);
                c_mul_b = 27'(r_dy);
            end
            ppo_pkg::ST_SQ_GO: begin
                c_cmd.start = 1'b1;
                c_cmd.sqrt  = 1'b1;
                c_cmd.steps = ppo_pkg::SQRT_STEPS;
                c_urem      = {2'b00, r_l2 + r_prod[49:0], 12'd0};
            end
            ppo_pkg::ST_UX_GO: begin
                c_cmd.start = 1'b1;
                c_cmd.steps = ppo_pkg::UDIV_STEPS;
                c_urem = 64'({ady, 36'd0} + 61'(u_q[30:1])) >> 32;
                c_ulow = 32'({ady, 36'd0} + 61'(u_q[30:1]));
                c_uden = 64'(u_q[30:0]);
            end
            ppo_pkg::ST_UY_GO: begin
                c_mul_a     = $signed({1'b0, u_q});
                c_mul_b     = $signed({3'b000, dm});
                c_cmd.start = 1'b1;
                c_cmd.steps = ppo_pkg::UDIV_STEPS;
                c_urem      = 64'(c_un_x[60:32]);
                c_ulow      = c_un_x[31:0];
                c_uden      = 64'(r_s);
            end
            ppo_pkg::ST_NY_MUL: begin
                c_mul_a = $signed({1'b0, u_q});
                c_mul_b = $signed({3'b000, dm});
            end
            ppo_pkg::ST_DEN1: begin
                c_mul_a = 33'(r_sdx);
                c_mul_b = 27'(r_dy);
            end
            ppo_pkg::ST_DEN2: begin
                c_mul_a = 33'(r_sdy);
                c_mul_b = 27'(r_dx);
            end
            ppo_pkg::ST_NUM1: begin
                c_mul_a = 33'(25'(r_ax) - 25'(r_ssx));
                c_mul_b = 27'(r_dy);
            end
            ppo_pkg::ST_NUM2: begin
                c_mul_a = 33'(25'(r_ay) - 25'(r_ssy));
                c_mul_b = 27'(r_dx);
            end
            ppo_pkg::ST_MLO: begin
                c_mul_a = $signed({8'd0, a_sel});
                c_mul_b = $signed({1'b0, num_mag[25:0]});
            end
            ppo_pkg::ST_MHI: begin
                c_mul_a = $signed({8'd0, a_sel});
                c_mul_b = $signed({2'b00, num_mag[50:26]});
            end
            ppo_pkg::ST_DGO: begin
                c_cmd.start = !c_ovf;
                c_cmd.steps = ppo_pkg::CDIV_STEPS;
                c_urem      = 64'(c_n[77:27]);
                c_ulow      = {c_n[26:0], 5'd0};
                c_uden      = 64'(c_dd);
            end
            ppo_pkg::ST_CORNER: begin
                c_emit = slot_free;
                c_ex   = ppo_pkg::sat24(32'(r_ssx) + 32'(c_cx));
                c_ey   = ppo_pkg::sat24(32'(r_ssy) + 32'(c_cy));
            end
            ppo_pkg::ST_EMIT_A: begin
                c_emit = slot_free;
                c_ex   = r_ax;
                c_ey   = r_ay;
            end
            ppo_pkg::ST_END: begin
                c_emit  = slot_free;
                c_ex    = r_sex;
                c_ey    = r_sey;
                c_elast = 1'b1;
            end
            ppo_pkg::ST_ECHO: begin
                c_emit  = slot_free;
                c_elast = (r_left == CNT_W'(1));
            end
            default: begin
                c_emit = 1'b0;
            end
        endcase
    end

    assign n_ovalid = c_emit || (r_ovalid && i_out_stall);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ppo_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_dist   <= '0;
            r_count  <= '0;
            r_have   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_dist <= i_cfg_data;
            end
            case (r_state)
                ppo_pkg::ST_PASS: begin
                    // zero offset: drop the polyline only on its last vertex
                    if (slot_free && r_last) begin
                        r_count <= '0;
                        r_have  <= 1'b0;
                    end
                end
                ppo_pkg::ST_CORNER, ppo_pkg::ST_EMIT_A: begin
                    if (slot_free) r_have <= 1'b1;
                end
                ppo_pkg::ST_TAIL: begin
                    r_count <= c_cnt_inc;
                end
                ppo_pkg::ST_END: begin
                    if (slot_free) begin
                        r_count <= '0;
                        r_have  <= 1'b0;
                    end
                end
                ppo_pkg::ST_ECHO: begin
                    if (slot_free && (r_left == CNT_W'(1))) begin
                        r_count <= '0;
                        r_have  <= 1'b0;
                    end
                end
                default: begin
                    r_have <= r_have;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= c_mul_a * c_mul_b;
        if (c_emit) begin
            r_ox    <= c_ex;
            r_oy    <= c_ey;
            r_olast <= c_elast;
        end
        case (r_state)
            ppo_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_x    <= i_in_x;
                    r_y    <= i_in_y;
                    r_last <= i_in_last;
                    r_dx   <= c_dx;
                    r_dy   <= c_dy;
                end
            end
            ppo_pkg::ST_L2Y:   r_l2 <= r_prod[49:0];
            ppo_pkg::ST_UX_GO: r_s  <= u_q[30:0];
            ppo_pkg::ST_NX: begin
                // x normal takes its size from |dy|
                r_nx <= (r_dy[24] == r_dist[23]) ? -c_nval : c_nval;
            end
            ppo_pkg::ST_NY: begin
                r_ny <= (r_dx[24] != r_dist[23]) ? -c_nval : c_nval;
            end
            ppo_pkg::ST_SHIFT: begin
                r_ax <= ppo_pkg::sat24(32'(r_prev_x) + 32'(r_nx));
                r_ay <= ppo_pkg::sat24(32'(r_prev_y) + 32'(r_ny));
                r_bx <= ppo_pkg::sat24(32'(r_x) + 32'(r_nx));
                r_by <= ppo_pkg::sat24(32'(r_y) + 32'(r_ny));
            end
            ppo_pkg::ST_DEN2: r_den <= r_prod[50:0];
            ppo_pkg::ST_NUM1: r_den <= r_den - r_prod[50:0];
            ppo_pkg::ST_NUM2: r_num <= r_prod[50:0];
            ppo_pkg::ST_CHK: begin
                r_num  <= r_num - r_prod[50:0];
                r_pass <= 1'b0;
            end
            ppo_pkg::ST_MHI: r_acc <= r_prod[51:0];
            ppo_pkg::ST_DGO: begin
                // quotient beyond the cap: skip the divide
                if (c_ovf) begin
                    if (r_pass) r_my <= ppo_pkg::CORNER_CAP;
                    else        r_mx <= ppo_pkg::CORNER_CAP;
                    r_pass <= 1'b1;
                end
            end
            ppo_pkg::ST_DCAP: begin
                if (r_pass) r_my <= c_qcap;
                else        r_mx <= c_qcap;
                r_pass <= 1'b1;
            end
            ppo_pkg::ST_CORNER, ppo_pkg::ST_EMIT_A: begin
                // advance the shifted line to the new segment
                if (slot_free) begin
                    r_ssx <= r_ax;
                    r_ssy <= r_ay;
                    r_sex <= r_bx;
                    r_sey <= r_by;
                    r_sdx <= r_dx;
                    r_sdy <= r_dy;
                end
            end
            ppo_pkg::ST_TAIL: begin
                r_prev_x <= r_x;
                r_prev_y <= r_y;
                r_left   <= c_cnt_inc;
            end
            ppo_pkg::ST_ECHO: begin
                if (slot_free) r_left <= r_left - CNT_W'(1);
            end
            default: begin
                r_pass <= r_pass;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_last  = r_olast;

endmodule

// ===== test/ppo_offset_checker.sv =====
// Checker of the polyline offset core: tracks the offset, predicts output vertices, compares.
`timescale 1ns / 1ps

module ppo_offset_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic signed [ppo_pkg::DATA_W-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic signed [ppo_pkg::DATA_W-1:0] i_in_x,
    input  logic signed [ppo_pkg::DATA_W-1:0] i_in_y,
    input  logic                              i_in_last,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [ppo_pkg::DATA_W-1:0] i_out_x,
    input  logic signed [ppo_pkg::DATA_W-1:0] i_out_y,
    input  logic                              i_out_last,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int          MAX_PTS = ppo_pkg::MAX_POINTS_DEF;
    localparam longint      CAP     = 64'd67108864;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               last;
    } t_vertex;

    t_vertex offset_pts[$];

    longint offset_val;
    longint last_x, last_y, line_ax, line_ay, line_bx, line_by, dir_x, dir_y;
    int     n_vertices;
    bit     line_valid;

    assign o_pending = offset_pts.size();

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint normal_comp(longint unsigned c, longint unsigned s,
                                           longint unsigned dm, bit neg);
        longint unsigned u, m;
        u = ((c << 36) + (s >> 1)) / s;
        m = (u * dm + (64'd1 << 29)) >> 30;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // round(a*b/d), ties away from zero, capped
    function automatic longint unsigned scaled_quot(longint unsigned a, longint unsigned b,
                                                    longint unsigned d);
        logic [127:0] p, q;
        p = 128'(a) * 128'(b);
        q = (2 * p + 128'(d)) / (2 * 128'(d));
        return (q > 128'(CAP)) ? CAP : q[63:0];
    endfunction

    function automatic void push_pt(longint x, longint y, bit last);
        t_vertex v;
        v.x = x[23:0];
        v.y = y[23:0];
        v.last = last;
        offset_pts.push_back(v);
    endfunction

    function automatic void drop_polyline();
        last_x = 0; last_y = 0; n_vertices = 0; line_valid = 0;
        line_ax = 0; line_ay = 0; line_bx = 0; line_by = 0; dir_x = 0; dir_y = 0;
    endfunction

    function automatic void offset_vertex(longint x, longint y, bit last);
        longint dx, dy, nx, ny, ax, ay, bx, by, den, num, cx, cy;
        longint unsigned adx, ady, dm, s, mx, my;
        bit sn;
        if (offset_val == 0) begin
            push_pt(x, y, last);
            if (last) drop_polyline();
            return;
        end
        if (n_vertices > 0 && (x != last_x || y != last_y)) begin
            dx = x - last_x; dy = y - last_y;
            adx = abs64(dx); ady = abs64(dy); dm = abs64(offset_val);
            s  = root64((adx * adx + ady * ady) << 12);
            nx = normal_comp(ady, s, dm, (dy < 0) == (offset_val < 0));
            ny = normal_comp(adx, s, dm, (dx < 0) != (offset_val < 0));
            ax = clamp24(last_x + nx); ay = clamp24(last_y + ny);
            bx = clamp24(x + nx);      by = clamp24(y + ny);
            den = dir_x * dy - dir_y * dx;
            if (!line_valid || den == 0) begin
                push_pt(ax, ay, 0);
            end else begin
                num = (ax - line_ax) * dy - (ay - line_ay) * dx;
                sn  = (num < 0) != (den < 0);
                mx  = scaled_quot(abs64(dir_x), abs64(num), abs64(den));
                my  = scaled_quot(abs64(dir_y), abs64(num), abs64(den));
                cx  = ((dir_x < 0) != sn) ? -longint'(mx) : longint'(mx);
                cy  = ((dir_y < 0) != sn) ? -longint'(my) : longint'(my);
                push_pt(clamp24(line_ax + cx), clamp24(line_ay + cy), 0);
            end
            line_ax = ax; line_ay = ay; line_bx = bx; line_by = by;
            dir_x = dx; dir_y = dy;
            line_valid = 1;
        end
        last_x = x; last_y = y;
        if (n_vertices < MAX_PTS) n_vertices++;
        if (last) begin
            if (line_valid) begin
                push_pt(line_bx, line_by, 1);
            end else begin
                for (int i = 0; i < n_vertices; i++) push_pt(x, y, i + 1 == n_vertices);
            end
            drop_polyline();
        end
    endfunction

    initial begin
        o_fail_count = 0;
        offset_val = 0;
        drop_polyline();
    end

    always @(posedge i_clk) begin
        t_vertex e;
        if (!i_rst_n) begin
            offset_val = 0;
            drop_polyline();
            offset_pts.delete();
        end else begin
            if (i_cfg_we) offset_val = longint'(i_cfg_data);
            if (i_in_valid && !i_in_stall)
                offset_vertex(longint'(i_in_x), longint'(i_in_y), i_in_last);
            if (i_out_valid && !i_out_stall) begin
                if (offset_pts.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected vertex x=%0d y=%0d last=%0b",
                                 i_out_x, i_out_y, i_out_last);
                end else begin
                    e = offset_pts.pop_front();
                    if (e.x !== i_out_x || e.y !== i_out_y || e.last !== i_out_last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                                     e.x, e.y, e.last, i_out_x, i_out_y, i_out_last);
                    end
                end
            end
        end
    end

endmodule

// ===== test/tb_polyline_parallel_offset_core.sv =====
// Testbench top of the polyline offset core: stimulus, receiver, watchdog and verdict.
`timescale 1ns / 1ps

module tb_polyline_parallel_offset_core;

    localparam int IDLE_LIMIT = 30000;   // cycles with no item moving
    localparam int SETTLE     = 400;     // covers a repeated vertex that emits nothing
    localparam int HOLD_OFF   = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic signed [23:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic signed [23:0] i_in_x;
    logic signed [23:0] i_in_y;
    logic        i_in_last;
    logic        o_out_valid;
    logic        i_out_stall;
    logic signed [23:0] o_out_x;
    logic signed [23:0] o_out_y;
    logic        o_out_last;

    int fail_count;
    int pending;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;
    int sent;
    bit hold_req;

    polyline_parallel_offset_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_x      (i_in_x),
        .i_in_y      (i_in_y),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_last  (o_out_last)
    );

    ppo_offset_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_x       (i_in_x),
        .i_in_y       (i_in_y),
        .i_in_last    (i_in_last),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_x      (o_out_x),
        .i_out_y      (o_out_y),
        .i_out_last   (o_out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall, or a long hold-off on request so the core backs up.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: count cycles in which no item moves on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Offer one vertex, idling first at random, and hold it until accepted.
    task automatic send_vertex(input logic [23:0] x, input logic [23:0] y, input bit last);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_x     <= x;
        i_in_y     <= y;
        i_in_last  <= last;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    // Drain, let any silent vertex finish, then write the offset.
    task automatic set_offset(input logic [23:0] value);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [23:0] rand_coord(input int scale);
        if (scale == 0) return 24'($urandom);
        return 24'($urandom_range(2 * scale) - scale);
    endfunction

    function automatic logic [23:0] rand_offset();
        case ($urandom_range(5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom);
            default: return 24'($urandom_range(4096) - 2048);
        endcase
    endfunction

    // One random polyline: mostly proper runs with parallel and repeated steps mixed in.
    task automatic random_polyline();
        int scale, n, kind;
        logic [23:0] x, y, sx, sy;
        kind  = $urandom_range(19);
        scale = ($urandom_range(9) == 0) ? 0 : ($urandom_range(1) ? 3000 : 300000);
        x = rand_coord(scale);
        y = rand_coord(scale);
        if (kind == 0) begin
            // lone point, possibly repeated past the echo limit
            n = ($urandom_range(3) == 0) ? 70 : $urandom_range(1, 4);
            for (int i = 0; i < n; i++) send_vertex(x, y, i == n - 1);
            return;
        end
        n  = $urandom_range(2, 8);
        sx = rand_coord(scale / 8);
        sy = rand_coord(scale / 8);
        for (int i = 0; i < n; i++) begin
            send_vertex(x, y, i == n - 1);
            case ($urandom_range(9))
                0: ;                                    // repeat the vertex
                1: begin x = x + sx; y = y + sy; end    // carry on straight
                2: begin sx = -sx; sy = -sy; x = x + sx; y = y + sy; end
                default: begin
                    sx = rand_coord(scale / 4);
                    sy = rand_coord(scale / 4);
                    x = x + sx;
                    y = y + sy;
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_x     = '0;
        i_in_y     = '0;
        i_in_last  = 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_req   = 1'b0;
        quiet_cycles = 0;
        sent       = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a square, straight and reversed runs, repeats, lone points.
        set_offset(24'd256);
        send_vertex(0, 0, 0);
        send_vertex(2560, 0, 0);
        send_vertex(2560, 2560, 0);
        send_vertex(0, 2560, 1);
        send_vertex(0, 0, 0);
        send_vertex(100, 0, 0);
        send_vertex(300, 0, 1);
        send_vertex(0, 0, 0);
        send_vertex(500, 0, 0);
        send_vertex(100, 0, 1);
        send_vertex(0, 0, 0);
        send_vertex(0, 0, 0);
        send_vertex(400, 300, 1);
        send_vertex(5, 5, 1);
        send_vertex(7, 7, 0);
        send_vertex(7, 7, 0);
        send_vertex(7, 7, 1);
        send_vertex(24'h800000, 24'h800000, 0);
        send_vertex(24'h7FFFFF, 24'h7FFFFF, 1);
        // Change the offset in the middle of a polyline.
        send_vertex(0, 0, 0);
        send_vertex(1000, 0, 0);
        set_offset(-24'sd512);
        send_vertex(1000, 1000, 1);
        // Zero offset passes points through and drops the polyline on last.
        set_offset(24'd0);
        send_vertex(123, -24'sd45, 0);
        send_vertex(24'h7FFFFF, 24'h800000, 1);
        set_offset(24'h7FFFFF);
        send_vertex(0, 0, 0);
        send_vertex(24'h7FFFFF, 24'h000100, 0);
        send_vertex(24'h800000, 24'h7FFFFF, 1);
        set_offset(24'h800000);
        send_vertex(24'h400000, 0, 0);
        send_vertex(0, 24'h400000, 0);
        send_vertex(24'hC00000, 0, 1);

        // Random phases: none, sender idle, receiver stalling, both.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 77 : 27) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 77 : 27) : 0;
            for (int k = 0; k < 4; k++) begin
                set_offset(rand_offset());
                if (ph == 0 && k == 1) hold_req = 1'b1;
                repeat (5) random_polyline();
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
